@@ src/scbp_pkg.sv @@
// Shared types and constants for the servo command byte parser.
package scbp_pkg;

  localparam logic [3:0] HDR_NIBBLE_A = 4'h8;
  localparam logic [3:0] HDR_NIBBLE_B = 4'hF;
  localparam logic [7:0] PULSE_SCALE  = 8'd100;

  localparam int CODE_W  = 4;
  localparam int WIDTH_W = 15;
  localparam int INDEX_W = 5;
  localparam int MASK_W  = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_CODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 3'd5;

  typedef enum logic [1:0] {
    KIND_RELAY_ON  = 2'd0,
    KIND_RELAY_OFF = 2'd1,
    KIND_PULSE     = 2'd2,
    KIND_LED       = 2'd3
  } event_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_LED  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [CODE_W-1:0]  enable_code;
    logic [CODE_W-1:0]  disable_code;
    logic [CODE_W-1:0]  pulse_code;
    logic [CODE_W-1:0]  led_code;
    logic [WIDTH_W-1:0] pulse_min;
    logic [WIDTH_W-1:0] pulse_max;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    event_kind_t        kind;
    logic [INDEX_W-1:0] servo_index;
    logic [WIDTH_W-1:0] pulse_width;
    logic [MASK_W-1:0]  led_mask;
  } result_t;

endpackage

@@ src/scbp_parser.sv @@
// Command decoder: parse state machine and per-byte result generation.
module scbp_parser #(
  parameter int SERVO_COUNT = 18,
  parameter int LED_COUNT   = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  scbp_pkg::cfg_t       cfg,
  output scbp_pkg::result_t    res
);

  localparam logic [7:0] LED_KEEP = 8'((9'd1 << LED_COUNT) - 9'd1);
  localparam logic [scbp_pkg::INDEX_W:0] SERVO_LAST = (scbp_pkg::INDEX_W+1)'(SERVO_COUNT);

  scbp_pkg::phase_t             phase_r, phase_nxt;
  logic [scbp_pkg::INDEX_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                   high_r, high_nxt;

  logic                         hdr_ok;
  logic [3:0]                   cmd;
  logic [15:0]                  prod;
  logic [scbp_pkg::WIDTH_W-1:0] width;
  logic                         in_range;
  logic [scbp_pkg::INDEX_W:0]   cnt_inc;
  logic                         last_servo;
  logic [7:0]                   led_bits;

  assign cmd        = rx_byte[3:0];
  assign hdr_ok     = (rx_byte[7:4] == scbp_pkg::HDR_NIBBLE_A) ||
                      (rx_byte[7:4] == scbp_pkg::HDR_NIBBLE_B);
  assign prod       = 16'(high_r) * 16'(scbp_pkg::PULSE_SCALE);
  assign width      = scbp_pkg::WIDTH_W'(prod + 16'(rx_byte));
  assign in_range   = (width >= cfg.pulse_min) && (width <= cfg.pulse_max);
  assign cnt_inc    = {1'b0, cnt_r} + (scbp_pkg::INDEX_W+1)'(1);
  assign last_servo = cnt_inc >= SERVO_LAST;
  assign led_bits   = rx_byte & LED_KEEP;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    high_nxt  = high_r;
    res       = '0;
    res.kind  = scbp_pkg::KIND_RELAY_ON;
    unique case (phase_r)
      scbp_pkg::PH_IDLE: begin
        if (hdr_ok) begin
          priority if (cmd == cfg.enable_code) begin
            phase_nxt = scbp_pkg::PH_HIGH;
            cnt_nxt   = '0;
            res.valid = 1'b1;
            res.kind  = scbp_pkg::KIND_RELAY_ON;
          end else if (cmd == cfg.disable_code) begin
            res.valid = 1'b1;
            res.kind  = scbp_pkg::KIND_RELAY_OFF;
          end else if (cmd == cfg.pulse_code) begin
            phase_nxt = scbp_pkg::PH_HIGH;
            cnt_nxt   = '0;
          end else if (cmd == cfg.led_code) begin
            phase_nxt = scbp_pkg::PH_LED;
          end else begin
            phase_nxt = scbp_pkg::PH_IDLE;
          end
        end
      end
      scbp_pkg::PH_HIGH: begin
        high_nxt  = rx_byte;
        phase_nxt = scbp_pkg::PH_LOW;
      end
      scbp_pkg::PH_LOW: begin
        if (in_range) begin
          res.valid       = 1'b1;
          res.kind        = scbp_pkg::KIND_PULSE;
          res.servo_index = cnt_r;
          res.pulse_width = width;
        end
        if (last_servo) begin
          cnt_nxt   = '0;
          phase_nxt = scbp_pkg::PH_IDLE;
        end else begin
          cnt_nxt   = cnt_inc[scbp_pkg::INDEX_W-1:0];
          phase_nxt = scbp_pkg::PH_HIGH;
        end
      end
      scbp_pkg::PH_LED: begin
        res.valid    = 1'b1;
        res.kind     = scbp_pkg::KIND_LED;
        res.led_mask = led_bits[scbp_pkg::MASK_W-1:0];
        phase_nxt    = scbp_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = scbp_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scbp_pkg::PH_IDLE;
      cnt_r   <= '0;
      high_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

@@ src/servo_command_byte_parser.sv @@
// Top level of the servo command byte parser: config registers and result register.
// One received byte is accepted per cycle unless stalled and its event, if any, appears
// in the result register on the next cycle; in_stall rises only while that register
// holds an event that the receiver is stalling, so throughput is otherwise one byte per
// clock. A header with high nibble 8 or F selects enable (relay-on, then pulse load),
// disable (relay-off), pulse load or LED mask; a pulse load reads a high and a low byte
// per servo, width = high*100 + low, reported only when within pulse_min..pulse_max.
// Codes that match several registers resolve in the order enable, disable, pulse, LED.
module servo_command_byte_parser #(
  parameter int SERVO_COUNT = 18,
  parameter int LED_COUNT   = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_event_kind,
  output logic [scbp_pkg::INDEX_W-1:0]    out_servo_index,
  output logic [scbp_pkg::WIDTH_W-1:0]    out_pulse_width,
  output logic [scbp_pkg::MASK_W-1:0]     out_led_mask,
  input  logic                            cfg_we,
  input  logic [scbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbp_pkg::WIDTH_W-1:0]    cfg_wdata
);

  scbp_pkg::cfg_t    cfg_r;
  scbp_pkg::result_t res;
  scbp_pkg::result_t out_r;
  logic              out_valid_r;
  logic              accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  scbp_parser #(
    .SERVO_COUNT(SERVO_COUNT),
    .LED_COUNT  (LED_COUNT)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .rx_byte(in_rx_byte),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_code  <= 4'd1;
      cfg_r.disable_code <= 4'd2;
      cfg_r.pulse_code   <= 4'd3;
      cfg_r.led_code     <= 4'd4;
      cfg_r.pulse_min    <= 15'd500;
      cfg_r.pulse_max    <= 15'd2500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scbp_pkg::CFG_ENABLE_CODE:  cfg_r.enable_code  <= cfg_wdata[scbp_pkg::CODE_W-1:0];
        scbp_pkg::CFG_DISABLE_CODE: cfg_r.disable_code <= cfg_wdata[scbp_pkg::CODE_W-1:0];
        scbp_pkg::CFG_PULSE_CODE:   cfg_r.pulse_code   <= cfg_wdata[scbp_pkg::CODE_W-1:0];
        scbp_pkg::CFG_LED_CODE:     cfg_r.led_code     <= cfg_wdata[scbp_pkg::CODE_W-1:0];
        scbp_pkg::CFG_PULSE_MIN:    cfg_r.pulse_min    <= cfg_wdata;
        scbp_pkg::CFG_PULSE_MAX:    cfg_r.pulse_max    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_r.kind;
  assign out_servo_index = out_r.servo_index;
  assign out_pulse_width = out_r.pulse_width;
  assign out_led_mask    = out_r.led_mask;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  a_pulse_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind == scbp_pkg::KIND_PULSE) |->
      (out_pulse_width >= cfg_r.pulse_min && out_pulse_width <= cfg_r.pulse_max &&
       32'(out_servo_index) < SERVO_COUNT))
    else $error("pulse event outside limits or servo range");

  a_non_pulse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind != scbp_pkg::KIND_PULSE) |->
      (out_servo_index == '0 && out_pulse_width == '0))
    else $error("non-pulse event carries pulse fields");

endmodule
